// ===== rtl/tecg_pkg.sv =====
package tecg_pkg;

    localparam int DUR_W     = 32;
    localparam int DT_W      = 16;
    localparam int Q_W       = 17;
    localparam int SQ_W      = 2 * Q_W;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 40;

    localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
    localparam logic [Q_W-1:0] Q_HALF = 17'h08000;
    localparam logic [Q_W-1:0] Q_ZERO = 17'h00000;

    localparam logic [DUR_W-1:0] DURATION_RST = 32'd1000;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] EV_STARTED = 2'd0;
    localparam logic [1:0] EV_UPDATED = 2'd1;
    localparam logic [1:0] EV_ENDED   = 2'd2;

    localparam logic [2:0] SHAPE_ZERO   = 3'd0;
    localparam logic [2:0] SHAPE_ONE    = 3'd1;
    localparam logic [2:0] SHAPE_LINEAR = 3'd2;
    localparam logic [2:0] SHAPE_QIN    = 3'd3;
    localparam logic [2:0] SHAPE_QOUT   = 3'd4;
    localparam logic [2:0] SHAPE_QINOUT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_SHAPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_GROW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHAPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GROW  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_FADE,
        ST_MUL_ALPHA,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DUR_W-1:0] num;
        logic [DUR_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

    // operand that gets squared for a given shape
    function automatic logic [Q_W-1:0] sq_operand(input logic [Q_W-1:0] phase,
                                                  input logic [2:0] shape);
        logic [Q_W-1:0] q;
        q = Q_ONE - phase;
        case (shape)
            SHAPE_QOUT:   sq_operand = q;
            SHAPE_QINOUT: sq_operand = (phase < Q_HALF) ? phase : q;
            default:      sq_operand = phase;
        endcase
    endfunction

    function automatic logic [Q_W-1:0] ease_finish(input logic [Q_W-1:0]  phase,
                                                   input logic [2:0]      shape,
                                                   input logic            growing,
                                                   input logic [SQ_W-1:0] sq);
        logic [SQ_W-1:0] rnd16;
        logic [SQ_W-1:0] rnd15;
        logic [Q_W-1:0]  v16;
        logic [Q_W-1:0]  v15;
        logic [Q_W-1:0]  v;
        rnd16 = sq + SQ_W'(32768);
        rnd15 = sq + SQ_W'(16384);
        v16   = rnd16[32:16];
        v15   = rnd15[31:15];
        case (shape)
            SHAPE_QIN:    v = v16;
            SHAPE_QOUT:   v = Q_ONE - v16;
            SHAPE_QINOUT: v = (phase < Q_HALF) ? v15 : (Q_ONE - v15);
            default:      v = phase;
        endcase
        if (!growing) begin
            v = Q_ONE - v;
        end
        case (shape)
            SHAPE_ZERO: ease_finish = Q_ZERO;
            SHAPE_ONE:  ease_finish = Q_ONE;
            default:    ease_finish = v;
        endcase
    endfunction

endpackage

// ===== rtl/tecg_div.sv =====
module tecg_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tecg_pkg::t_div_req   i_req,
    output tecg_pkg::t_div_rsp   o_rsp
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [tecg_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [tecg_pkg::DUR_W:0]       r_rem, n_rem;
    logic [tecg_pkg::Q_W-1:0]       r_quot, n_quot;
    logic [tecg_pkg::DUR_W-1:0]     r_den, n_den;
    logic [tecg_pkg::DUR_W:0]       sh;
    logic [tecg_pkg::DUR_W+1:0]     diff;
    logic                           bit_q;

    // first step compares the remainder as loaded, later steps shift first
    assign sh    = (r_cnt == tecg_pkg::CNT_W'(tecg_pkg::DIV_STEPS)) ? r_rem
                 : {r_rem[tecg_pkg::DUR_W-1:0], 1'b0};
    assign diff  = {1'b0, sh} - {2'b00, r_den};
    assign bit_q = !diff[tecg_pkg::DUR_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = tecg_pkg::CNT_W'(tecg_pkg::DIV_STEPS);
            n_rem  = {1'b0, i_req.num};
            n_den  = i_req.den;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = bit_q ? diff[tecg_pkg::DUR_W:0] : sh;
            n_quot = {r_quot[tecg_pkg::Q_W-2:0], bit_q};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == tecg_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy && r_cnt == tecg_pkg::CNT_W'(tecg_pkg::DIV_STEPS))
        else $error("divider did not start");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == tecg_pkg::CNT_W'(1) && !i_req.start) |=> r_done)
        else $error("divider missed done");

endmodule

// ===== rtl/timed_easing_curve_generator_core.sv =====
// A tick that updates the curves goes through a 17-step restoring divide, phase
// load and two shared 17x17 squares before its result; start, stop and ending
// ticks skip the divide. Only one item is handled at a time; with the output free the
// next is taken once the result is loaded into the output register, and an item
// without a result does not hold up the next. Synchronous active-low reset
// restores register defaults, clears elapsed time and leaves the timer idle.
module timed_easing_curve_generator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tecg_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [15:0] delta_t
    input  logic [1:0]                          s_axis_tuser,  // [1:0] kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] fade_factor, [33:17] alpha_value, [34] is_running, [39:35] zero
    output logic [tecg_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // [1:0] event_res
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tecg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tecg_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    tecg_pkg::t_state               r_state, n_state;
    logic [tecg_pkg::DUR_W-1:0]     r_duration;
    logic [2:0]                     r_fade_shape;
    logic                           r_fade_grow;
    logic [2:0]                     r_alpha_shape;
    logic                           r_alpha_grow;
    logic [tecg_pkg::DUR_W-1:0]     r_elapsed;
    logic                           r_running;
    logic [1:0]                     r_event;
    logic [tecg_pkg::Q_W-1:0]       r_phase;
    logic [tecg_pkg::SQ_W-1:0]      r_prod;
    logic [tecg_pkg::Q_W-1:0]       r_fade;
    logic                           r_out_valid;
    logic [1:0]                     r_out_event;
    logic [tecg_pkg::Q_W-1:0]       r_out_fade;
    logic [tecg_pkg::Q_W-1:0]       r_out_alpha;
    logic                           r_out_run;

    logic                           accept;
    logic [1:0]                     kind;
    logic [tecg_pkg::DUR_W:0]       sum;
    logic                           over;
    logic                           do_start;
    logic                           do_stop;
    logic                           do_tick;
    logic                           out_free;
    logic                           out_load;
    logic [2:0]                     mul_shape;
    logic [tecg_pkg::Q_W-1:0]       mul_op;
    logic [tecg_pkg::Q_W-1:0]       quot_clamped;
    tecg_pkg::t_div_req             div_req;
    tecg_pkg::t_div_rsp             div_rsp;

    assign kind     = s_axis_tuser;
    assign sum      = {1'b0, r_elapsed} + (tecg_pkg::DUR_W + 1)'(s_axis_tdata);
    assign over     = sum > {1'b0, r_duration};
    assign out_free = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // control outputs
    always_comb begin
        s_axis_tready = (r_state == tecg_pkg::ST_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        do_start      = accept && kind == tecg_pkg::KIND_START && !r_running;
        do_stop       = accept && kind == tecg_pkg::KIND_STOP && r_running;
        do_tick       = accept && kind == tecg_pkg::KIND_TICK && r_running;
        out_load      = (r_state == tecg_pkg::ST_OUT) && out_free;
        div_req.start = do_tick && !over;
        div_req.num   = sum[tecg_pkg::DUR_W-1:0];
        div_req.den   = r_duration;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tecg_pkg::ST_IDLE: begin
                if (do_tick && !over) begin
                    n_state = tecg_pkg::ST_DIV;
                end else if (do_start || do_stop || do_tick) begin
                    n_state = tecg_pkg::ST_MUL_FADE;
                end
            end
            tecg_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = tecg_pkg::ST_MUL_FADE;
                end
            end
            tecg_pkg::ST_MUL_FADE:  n_state = tecg_pkg::ST_MUL_ALPHA;
            tecg_pkg::ST_MUL_ALPHA: n_state = tecg_pkg::ST_OUT;
            tecg_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = tecg_pkg::ST_IDLE;
                end
            end
            default: n_state = tecg_pkg::ST_IDLE;
        endcase
    end

    assign quot_clamped = (div_rsp.quot > tecg_pkg::Q_ONE) ? tecg_pkg::Q_ONE : div_rsp.quot;
    assign mul_shape    = (r_state == tecg_pkg::ST_MUL_FADE) ? r_fade_shape : r_alpha_shape;
    assign mul_op       = tecg_pkg::sq_operand(r_phase, mul_shape);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tecg_pkg::ST_IDLE;
            r_duration    <= tecg_pkg::DURATION_RST;
            r_fade_shape  <= tecg_pkg::SHAPE_LINEAR;
            r_fade_grow   <= 1'b1;
            r_alpha_shape <= tecg_pkg::SHAPE_ONE;
            r_alpha_grow  <= 1'b1;
            r_elapsed     <= '0;
            r_running     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tecg_pkg::CFG_DURATION:    r_duration    <= i_cfg_data;
                    tecg_pkg::CFG_FADE_SHAPE:  r_fade_shape  <= i_cfg_data[2:0];
                    tecg_pkg::CFG_FADE_GROW:   r_fade_grow   <= i_cfg_data[0];
                    tecg_pkg::CFG_ALPHA_SHAPE: r_alpha_shape <= i_cfg_data[2:0];
                    tecg_pkg::CFG_ALPHA_GROW:  r_alpha_grow  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (do_start) begin
                r_running <= 1'b1;
                r_elapsed <= '0;
            end else if (do_stop) begin
                r_running <= 1'b0;
            end else if (do_tick) begin
                r_elapsed <= sum[tecg_pkg::DUR_W] ? '1 : sum[tecg_pkg::DUR_W-1:0];
                if (over) begin
                    r_running <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (do_start) begin
            r_event <= tecg_pkg::EV_STARTED;
            r_phase <= tecg_pkg::Q_ZERO;
        end else if (do_stop || (do_tick && over)) begin
            r_event <= tecg_pkg::EV_ENDED;
            r_phase <= tecg_pkg::Q_ONE;
        end else if (do_tick) begin
            r_event <= tecg_pkg::EV_UPDATED;
        end
        if (r_state == tecg_pkg::ST_DIV && div_rsp.done) begin
            r_phase <= quot_clamped;
        end

        // shared squarer: fade operand first, then alpha
        if (r_state == tecg_pkg::ST_MUL_FADE || r_state == tecg_pkg::ST_MUL_ALPHA) begin
            r_prod <= tecg_pkg::SQ_W'(mul_op) * tecg_pkg::SQ_W'(mul_op);
        end
        if (r_state == tecg_pkg::ST_MUL_ALPHA) begin
            r_fade <= tecg_pkg::ease_finish(r_phase, r_fade_shape, r_fade_grow, r_prod);
        end
        if (out_load) begin
            r_out_event <= r_event;
            r_out_fade  <= r_fade;
            r_out_alpha <= tecg_pkg::ease_finish(r_phase, r_alpha_shape, r_alpha_grow, r_prod);
            r_out_run   <= r_running;
        end
    end

    tecg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event;
    assign m_axis_tdata  = {5'b00000, r_out_run, r_out_alpha, r_out_fade};

    a_div_leads_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tecg_pkg::ST_DIV && div_rsp.done) |=> r_state == tecg_pkg::ST_MUL_FADE)
        else $error("divide result not consumed");

    a_overrun_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_tick && over) |=> !r_running && r_event == tecg_pkg::EV_ENDED)
        else $error("overrun tick did not end timer");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tecg_pkg::ST_MUL_FADE) |-> r_phase <= tecg_pkg::Q_ONE)
        else $error("phase above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tecg_pkg::ST_OUT && !out_free) |=> r_state == tecg_pkg::ST_OUT)
        else $error("result dropped while output busy");

endmodule

// ===== tb/sv/timed_easing_curve_generator_core_tb.sv =====
`timescale 1ns / 1ps

module timed_easing_curve_generator_core_tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 40;
    localparam int NUM_SETTINGS = 12;
    localparam int ITEMS_EACH   = 100;

    typedef struct packed {
        logic [1:0]                kind;
        logic [tecg_pkg::DT_W-1:0] delta_t;
    } t_timer_cmd;

    typedef struct packed {
        logic [1:0]               ev;
        logic [tecg_pkg::Q_W-1:0] fade;
        logic [tecg_pkg::Q_W-1:0] alpha;
        logic                     running;
    } t_curve_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tecg_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [tecg_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tecg_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [tecg_pkg::CFG_DAT_W-1:0]   i_cfg_data = '0;

    t_timer_cmd    pending_cmds[$];
    t_curve_result expected_curves[$];

    // timer model state and register shadows
    logic [tecg_pkg::DUR_W-1:0] duration_cfg = tecg_pkg::DURATION_RST;
    logic [2:0]                 fade_shape_cfg = tecg_pkg::SHAPE_LINEAR;
    logic                       fade_grow_cfg = 1'b1;
    logic [2:0]                 alpha_shape_cfg = tecg_pkg::SHAPE_ONE;
    logic                       alpha_grow_cfg = 1'b1;
    logic [tecg_pkg::DUR_W-1:0] elapsed_ticks = '0;
    logic                       timer_running = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int cmds_accepted = 0;
    int n_started = 0;
    int n_updated = 0;
    int n_ended = 0;

    timed_easing_curve_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [tecg_pkg::Q_W-1:0] shape_curve(
        input logic [tecg_pkg::Q_W-1:0] ph,
        input logic [2:0] shape,
        input logic grow);
        logic [63:0]              pp;
        logic [63:0]              qq;
        logic [63:0]              t;
        logic [tecg_pkg::Q_W-1:0] v;
        pp = {47'b0, ph};
        qq = 64'd65536 - pp;
        if (shape == tecg_pkg::SHAPE_ZERO) return tecg_pkg::Q_ZERO;
        if (shape == tecg_pkg::SHAPE_ONE) return tecg_pkg::Q_ONE;
        case (shape)
            tecg_pkg::SHAPE_QIN: begin
                t = (pp * pp + 64'd32768) >> 16;
                v = t[tecg_pkg::Q_W-1:0];
            end
            tecg_pkg::SHAPE_QOUT: begin
                t = (qq * qq + 64'd32768) >> 16;
                v = tecg_pkg::Q_ONE - t[tecg_pkg::Q_W-1:0];
            end
            tecg_pkg::SHAPE_QINOUT: begin
                if (ph < tecg_pkg::Q_HALF) begin
                    t = (pp * pp + 64'd16384) >> 15;
                    v = t[tecg_pkg::Q_W-1:0];
                end else begin
                    t = (qq * qq + 64'd16384) >> 15;
                    v = tecg_pkg::Q_ONE - t[tecg_pkg::Q_W-1:0];
                end
            end
            default: v = ph;
        endcase
        if (!grow) v = tecg_pkg::Q_ONE - v;
        return v;
    endfunction

    task automatic expect_curves(input logic [1:0] ev, input logic [tecg_pkg::Q_W-1:0] ph);
        t_curve_result r;
        r.ev      = ev;
        r.fade    = shape_curve(ph, fade_shape_cfg, fade_grow_cfg);
        r.alpha   = shape_curve(ph, alpha_shape_cfg, alpha_grow_cfg);
        r.running = timer_running;
        expected_curves.push_back(r);
    endtask

    task automatic predict_timer(input t_timer_cmd c);
        logic [tecg_pkg::DUR_W:0] total;
        logic [63:0]              ph;
        case (c.kind)
            tecg_pkg::KIND_START: begin
                if (!timer_running) begin
                    timer_running = 1'b1;
                    elapsed_ticks = '0;
                    expect_curves(tecg_pkg::EV_STARTED, tecg_pkg::Q_ZERO);
                end
            end
            tecg_pkg::KIND_STOP: begin
                if (timer_running) begin
                    timer_running = 1'b0;
                    expect_curves(tecg_pkg::EV_ENDED, tecg_pkg::Q_ONE);
                end
            end
            tecg_pkg::KIND_TICK: begin
                if (timer_running) begin
                    total = {1'b0, elapsed_ticks} + {17'b0, c.delta_t};
                    elapsed_ticks = total[tecg_pkg::DUR_W] ? '1 : total[tecg_pkg::DUR_W-1:0];
                    if (total > {1'b0, duration_cfg}) begin
                        timer_running = 1'b0;
                        expect_curves(tecg_pkg::EV_ENDED, tecg_pkg::Q_ONE);
                    end else begin
                        if (duration_cfg == 0) begin
                            ph = 64'd65536;
                        end else begin
                            ph = ({32'b0, elapsed_ticks} << 16) / {32'b0, duration_cfg};
                        end
                        if (ph > 64'd65536) ph = 64'd65536;
                        expect_curves(tecg_pkg::EV_UPDATED, ph[tecg_pkg::Q_W-1:0]);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_timer_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                c.kind    = s_axis_tuser;
                c.delta_t = s_axis_tdata;
                predict_timer(c);
                cmds_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= c.kind;
                    s_axis_tdata  <= c.delta_t;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [tecg_pkg::Q_W-1:0] exp_v,
                               input logic [tecg_pkg::Q_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_curve_result e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_curves.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected beat, expected none, actual tuser %0h tdata %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    e = expected_curves.pop_front();
                    check_field("event", {15'b0, e.ev}, {15'b0, m_axis_tuser});
                    check_field("fade", e.fade, m_axis_tdata[16:0]);
                    check_field("alpha", e.alpha, m_axis_tdata[33:17]);
                    check_field("running", {16'b0, e.running}, {16'b0, m_axis_tdata[34]});
                    case (e.ev)
                        tecg_pkg::EV_STARTED: n_started++;
                        tecg_pkg::EV_UPDATED: n_updated++;
                        default:              n_ended++;
                    endcase
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [tecg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tecg_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tecg_pkg::CFG_DURATION:    duration_cfg = val;
            tecg_pkg::CFG_FADE_SHAPE:  fade_shape_cfg = val[2:0];
            tecg_pkg::CFG_FADE_GROW:   fade_grow_cfg = val[0];
            tecg_pkg::CFG_ALPHA_SHAPE: alpha_shape_cfg = val[2:0];
            tecg_pkg::CFG_ALPHA_GROW:  alpha_grow_cfg = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [tecg_pkg::DUR_W-1:0] dur, input logic [2:0] fs,
                             input logic fg, input logic [2:0] as, input logic ag);
        write_reg(tecg_pkg::CFG_DURATION, dur);
        write_reg(tecg_pkg::CFG_FADE_SHAPE, {29'b0, fs});
        write_reg(tecg_pkg::CFG_FADE_GROW, {31'b0, fg});
        write_reg(tecg_pkg::CFG_ALPHA_SHAPE, {29'b0, as});
        write_reg(tecg_pkg::CFG_ALPHA_GROW, {31'b0, ag});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_curves.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);
        // a beat launched in the last cycle above may still be in flight
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_curves.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_cmd(input logic [1:0] k, input logic [tecg_pkg::DT_W-1:0] d);
        t_timer_cmd c;
        c.kind    = k;
        c.delta_t = d;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [tecg_pkg::DT_W-1:0] tick_step(
        input logic [tecg_pkg::DUR_W-1:0] dur);
        logic [31:0] lim;
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(9) == 0) return r[tecg_pkg::DT_W-1:0];
        lim = dur / 6;
        if (lim > 65535) lim = 65535;
        if (lim == 0) lim = 1;
        r = $urandom_range(lim);
        return r[tecg_pkg::DT_W-1:0];
    endfunction

    // start, a run of ticks, maybe a stop; sometimes one random command instead, and stray starts among the ticks
    task automatic add_sequence(input logic [tecg_pkg::DUR_W-1:0] dur, output int counted);
        int          n;
        logic [31:0] r;
        counted = 0;
        if ($urandom_range(9) == 0) begin
            r = $urandom;
            push_cmd(r[17:16], r[15:0]);
            return;
        end
        r = $urandom;
        push_cmd(tecg_pkg::KIND_START, r[15:0]);
        counted++;
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                r = $urandom;
                push_cmd(tecg_pkg::KIND_START, r[15:0]);
            end
            push_cmd(tecg_pkg::KIND_TICK, tick_step(dur));
            counted++;
        end
        if ($urandom_range(2) == 0) begin
            r = $urandom;
            push_cmd(tecg_pkg::KIND_STOP, r[15:0]);
            counted++;
        end
    endtask

    function automatic logic [tecg_pkg::DUR_W-1:0] setting_duration(input int idx);
        case (idx)
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1000;
            3:       return 32'd0;
            4:       return 32'd3;
            5:       return 32'd65535;
            6:       return 32'd17;
            7:       return 32'h0010_0000;
            8:       return 32'd2;
            9:       return 32'd300;
            default: return $urandom_range(5000, 1);
        endcase
    endfunction

    initial begin
        logic [tecg_pkg::DUR_W-1:0] dur;
        logic [2:0]                 fs;
        logic [2:0]                 as;
        int                         counted;
        int                         c;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        push_cmd(tecg_pkg::KIND_START, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'd100);
        push_cmd(tecg_pkg::KIND_STOP, 16'hFFFF);
        settle();

        configure(32'd1000, tecg_pkg::SHAPE_QINOUT, 1'b0, tecg_pkg::SHAPE_QOUT, 1'b1);
        push_cmd(tecg_pkg::KIND_STOP, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'd5);
        push_cmd(tecg_pkg::KIND_RSVD, 16'hFFFF);
        push_cmd(tecg_pkg::KIND_START, 16'h1234);
        push_cmd(tecg_pkg::KIND_START, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'd0);
        push_cmd(tecg_pkg::KIND_TICK, 16'd250);
        push_cmd(tecg_pkg::KIND_TICK, 16'd250);
        push_cmd(tecg_pkg::KIND_RSVD, 16'd0);
        push_cmd(tecg_pkg::KIND_TICK, 16'd500);
        push_cmd(tecg_pkg::KIND_TICK, 16'd1);
        push_cmd(tecg_pkg::KIND_START, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'hFFFF);
        push_cmd(tecg_pkg::KIND_START, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'd999);
        push_cmd(tecg_pkg::KIND_STOP, 16'h0000);
        push_cmd(tecg_pkg::KIND_START, 16'h0000);
        push_cmd(tecg_pkg::KIND_TICK, 16'h8000);
        push_cmd(tecg_pkg::KIND_STOP, 16'hAAAA);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle();
            case (s % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            dur = setting_duration(s);
            fs  = 3'(s % 8);
            as  = 3'((s + 3) % 8);
            configure(dur, fs, s[0], as, s[1]);
            counted = 0;
            while (counted < ITEMS_EACH) begin
                add_sequence(dur, c);
                counted += c;
            end
        end
        settle();

        $display("Ran %0d commands over %0d curve settings with mixed stalls",
                 cmds_accepted, NUM_SETTINGS + 2);
        $display("Checked %0d started, %0d updated, %0d ended results",
                 n_started, n_updated, n_ended);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
